// ----- hw/rtl/tcf_pkg.sv -----
// ----------------------------------------------------------------------------
// tcf_pkg
// Shared types, constants and the seven-segment digit table for the
// temperature reading to Fahrenheit segments block.
// ----------------------------------------------------------------------------
package tcf_pkg;

  // Fahrenheit in tenths: at most 320 + 9 * 255 = 2615
  localparam int unsigned F10_W   = 12;
  localparam int unsigned F10_MAX = 2615;
  localparam logic [F10_W-1:0] F10_BASE = 12'd320;

  // floor(v / 10) = (v * 52429) >> 19, exact for v below 2**16
  localparam int unsigned RECIP_W     = 16;
  localparam logic [RECIP_W-1:0] RECIP_TEN = 16'd52429;
  localparam int unsigned RECIP_SHIFT = 19;
  localparam int unsigned QUOT_W      = F10_W + RECIP_W - RECIP_SHIFT;

  // digit positions, in emission order
  localparam logic [1:0] POS_TENTHS = 2'd0;
  localparam logic [1:0] POS_ONES   = 2'd1;
  localparam logic [1:0] POS_TENS   = 2'd2;
  localparam logic [1:0] POS_SIGN   = 2'd3;

  localparam logic [7:0] SEG_DASH  = 8'h40;
  localparam logic [7:0] SEG_BLANK = 8'h00;
  localparam logic [7:0] SEG_DP    = 8'h80;

  // one queued reading: Fahrenheit tenths and the sign of the Celsius word
  typedef struct packed {
    logic             neg;
    logic [F10_W-1:0] f10;
  } entry_t;

  // segment code for a decimal digit, bits 6..0 are segments g..a
  function automatic logic [7:0] seg_of(input logic [3:0] digit);
    logic [7:0] seg;
    unique case (digit)
      4'd0:    seg = 8'h3f;
      4'd1:    seg = 8'h06;
      4'd2:    seg = 8'h5b;
      4'd3:    seg = 8'h4f;
      4'd4:    seg = 8'h66;
      4'd5:    seg = 8'h6d;
      4'd6:    seg = 8'h7c;
      4'd7:    seg = 8'h07;
      4'd8:    seg = 8'h7f;
      4'd9:    seg = 8'h67;
      default: seg = SEG_BLANK;
    endcase
    return seg;
  endfunction

endpackage

// ----- hw/rtl/tcf_front.sv -----
// ----------------------------------------------------------------------------
// tcf_front
// Classifies a sensor word by sign and converts it to Fahrenheit tenths.
// ----------------------------------------------------------------------------
module tcf_front (
  input  logic [15:0]       raw_reading,
  output tcf_pkg::entry_t   entry
);

  logic                          neg;
  logic [15:0]                   mag;
  logic [7:0]                    halves;
  logic [tcf_pkg::F10_W-1:0]     h9;

  assign neg    = raw_reading[15];
  assign mag    = neg ? (~raw_reading + 16'd1) : raw_reading;
  assign halves = {mag[14:8], mag[7]};
  // 9 * h as shift and add
  assign h9     = {1'b0, halves, 3'b000} + {4'b0000, halves};

  always_comb begin
    entry.neg = neg;
    if (!neg) begin
      entry.f10 = tcf_pkg::F10_BASE + h9;
    end else if (h9 > tcf_pkg::F10_BASE) begin
      entry.f10 = '0;   // below zero Fahrenheit: clamp
    end else begin
      entry.f10 = tcf_pkg::F10_BASE - h9;
    end
  end

endmodule

// ----- hw/rtl/tcf_queue.sv -----
// ----------------------------------------------------------------------------
// tcf_queue
// Two-entry queue between the front conversion and the digit sequencer.
// ----------------------------------------------------------------------------
module tcf_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  tcf_pkg::entry_t   push_data,
  input  logic              pop,
  output tcf_pkg::entry_t   pop_data,
  output logic              full,
  output logic              empty
);

  tcf_pkg::entry_t mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;

  assign full     = (count_r == 2'd2);
  assign empty    = (count_r == 2'd0);
  assign pop_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ push;
    rd_ptr_nxt = rd_ptr_r ^ pop;
    count_nxt  = count_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    full |-> !push)
    else $error("queue push while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    empty |-> !pop)
    else $error("queue pop while empty");

endmodule

// ----- hw/rtl/tcf_back.sv -----
// ----------------------------------------------------------------------------
// tcf_back
// Digit sequencer: peels one decimal digit per beat off the queued value
// and drives the registered result channel.
// ----------------------------------------------------------------------------
module tcf_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_empty,
  input  tcf_pkg::entry_t   q_data,
  output logic              q_pop,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [1:0]        out_digit_position,
  output logic [7:0]        out_segment_pattern,
  output logic              out_last_digit
);

  logic                            busy_r, busy_nxt;
  logic [1:0]                      pos_r, pos_nxt;
  logic [tcf_pkg::F10_W-1:0]       val_r, val_nxt;
  logic                            neg_r, neg_nxt;

  logic                            out_valid_r;
  logic [1:0]                      out_pos_r;
  logic [7:0]                      out_seg_r;
  logic                            out_last_r;

  logic                            fire;
  logic [tcf_pkg::F10_W+tcf_pkg::RECIP_W-1:0] prod;
  logic [tcf_pkg::QUOT_W-1:0]      quot;
  logic [tcf_pkg::F10_W:0]         quot10;
  logic [tcf_pkg::F10_W:0]         diff;
  logic [3:0]                      digit;
  logic [7:0]                      seg;

  // divide by ten via reciprocal multiply
  assign prod   = (tcf_pkg::F10_W+tcf_pkg::RECIP_W)'(val_r) * tcf_pkg::RECIP_TEN;
  assign quot   = prod[tcf_pkg::F10_W+tcf_pkg::RECIP_W-1:tcf_pkg::RECIP_SHIFT];
  assign quot10 = {1'b0, quot, 3'b000} + {3'b000, quot, 1'b0};
  assign diff   = {1'b0, val_r} - quot10;
  assign digit  = diff[3:0];

  always_comb begin
    unique case (pos_r)
      tcf_pkg::POS_TENTHS: seg = tcf_pkg::seg_of(digit);
      tcf_pkg::POS_ONES:   seg = tcf_pkg::seg_of(digit) | tcf_pkg::SEG_DP;
      tcf_pkg::POS_TENS:   seg = tcf_pkg::seg_of(digit);
      tcf_pkg::POS_SIGN:   seg = neg_r ? tcf_pkg::SEG_DASH : tcf_pkg::SEG_BLANK;
      default:             seg = tcf_pkg::SEG_BLANK;
    endcase
  end

  assign fire  = busy_r && (!out_valid_r || !out_stall);
  // load a new reading when idle or while the sign beat goes out
  assign q_pop = !q_empty && (!busy_r || (fire && pos_r == tcf_pkg::POS_SIGN));

  always_comb begin
    busy_nxt = busy_r;
    pos_nxt  = pos_r;
    val_nxt  = val_r;
    neg_nxt  = neg_r;
    if (fire) begin
      pos_nxt = pos_r + 2'd1;
      val_nxt = tcf_pkg::F10_W'(quot);
      if (pos_r == tcf_pkg::POS_SIGN) begin
        busy_nxt = 1'b0;
      end
    end
    if (q_pop) begin
      busy_nxt = 1'b1;
      pos_nxt  = tcf_pkg::POS_TENTHS;
      val_nxt  = q_data.f10;
      neg_nxt  = q_data.neg;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      pos_r       <= tcf_pkg::POS_TENTHS;
      out_valid_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      pos_r  <= pos_nxt;
      if (fire) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
    neg_r <= neg_nxt;
    if (fire) begin
      out_pos_r  <= pos_r;
      out_seg_r  <= seg;
      out_last_r <= (pos_r == tcf_pkg::POS_SIGN);
    end
  end

  assign out_valid           = out_valid_r;
  assign out_digit_position  = out_pos_r;
  assign out_segment_pattern = out_seg_r;
  assign out_last_digit      = out_last_r;

  a_last_on_sign: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_last_r == (out_pos_r == tcf_pkg::POS_SIGN)))
    else $error("last flag not on sign position");

  a_val_range: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> (val_r <= tcf_pkg::F10_W'(tcf_pkg::F10_MAX)))
    else $error("digit value out of range");

endmodule

// ----- hw/rtl/temp_reading_to_fahrenheit_segments_top.sv -----
// ----------------------------------------------------------------------------
// temp_reading_to_fahrenheit_segments_top
// Converts a signed half-degree Celsius sensor word to Fahrenheit tenths and
// emits four seven-segment beats: tenths, ones with point, tens, sign.
// ----------------------------------------------------------------------------
//
//  channel  | ports                                          | direction
//  ---------+------------------------------------------------+----------
//  input    | in_valid, in_stall, in_raw_reading[15:0]       | 1 beat in
//  result   | out_valid, out_stall, out_digit_position[1:0], | 4 beats out
//           | out_segment_pattern[7:0], out_last_digit       |
//
//  Rate: the digit sequencer emits one beat per cycle while out_stall is low;
//  its single divide-by-ten unit peels off one digit per beat.
//  Path: queue entry, then sequencer value register, then output register.
//  Reset: rst_n synchronous active low; clears the queue and the sequencer.
//  Stalls: a two-entry queue lets the input keep accepting while the result
//  side stalls; in_stall rises only when the queue is full.
//
module temp_reading_to_fahrenheit_segments_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [15:0] in_raw_reading,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_digit_position,
  output logic [7:0]  out_segment_pattern,
  output logic        out_last_digit
);

  tcf_pkg::entry_t front_entry;
  tcf_pkg::entry_t q_data;
  logic            q_full;
  logic            q_empty;
  logic            q_pop;
  logic            push;

  // front: sign classification and Fahrenheit conversion
  tcf_front u_front (
    .raw_reading (in_raw_reading),
    .entry       (front_entry)
  );

  assign in_stall = q_full;
  assign push     = in_valid && !q_full;

  tcf_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (front_entry),
    .pop       (q_pop),
    .pop_data  (q_data),
    .full      (q_full),
    .empty     (q_empty)
  );

  // back: one digit per beat into the output register
  tcf_back u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .q_empty             (q_empty),
    .q_data              (q_data),
    .q_pop               (q_pop),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_digit_position  (out_digit_position),
    .out_segment_pattern (out_segment_pattern),
    .out_last_digit      (out_last_digit)
  );

endmodule
